FILE: sv/mgcs_pkg.sv
package mgcs_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int ROW_W        = 16;
   localparam int VIDX_W       = 4;
   localparam int COLOR_W      = 5;

   typedef struct packed {
      logic [ROW_W-1:0] adjacency_row;
      logic             last_row;
   } req_type;

   typedef struct packed {
      logic [VIDX_W-1:0]  vertex_index;
      logic [COLOR_W-1:0] assigned_color;
      logic [COLOR_W-1:0] colors_used;
      logic               last_vertex;
   } rsp_type;

   // microprogram addresses
   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_TRIAL,
      STEP_LOADC,
      STEP_TEST,
      STEP_CHECK,
      STEP_INCC,
      STEP_PLACE,
      STEP_FAIL,
      STEP_DEC,
      STEP_NEXTM,
      STEP_INCM,
      STEP_GIVEUP,
      STEP_EMITPREP,
      STEP_EMIT
   } step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_START,
      COND_C_OVER,
      COND_FITS,
      COND_V_LAST,
      COND_V_ZERO,
      COND_M_FULL,
      COND_OUT_LAST
   } cond_type;

   typedef struct packed {
      logic      accept_req;
      logic      set_m1;
      logic      inc_m;
      logic      clr_colors;
      logic      clr_v;
      logic      inc_v;
      logic      dec_v;
      logic      load_c;
      logic      inc_c;
      logic      write_c;
      logic      clr_color_v;
      logic      clr_o;
      logic      emit;
      cond_type  cond;
      step_type  jump_t;
      step_type  jump_f;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(step_type s);
      ctrl_word_type w;
      begin
         w        = '0;
         w.cond   = COND_ALWAYS;
         w.jump_t = STEP_IDLE;
         w.jump_f = STEP_IDLE;
         unique case (s)
            STEP_IDLE: begin
               w.accept_req = 1'b1;
               w.set_m1     = 1'b1;
               w.cond       = COND_START;
               w.jump_t     = STEP_TRIAL;
               w.jump_f     = STEP_IDLE;
            end
            STEP_TRIAL: begin
               w.clr_colors = 1'b1;
               w.clr_v      = 1'b1;
               w.jump_t     = STEP_LOADC;
               w.jump_f     = STEP_LOADC;
            end
            STEP_LOADC: begin
               w.load_c = 1'b1;
               w.jump_t = STEP_TEST;
               w.jump_f = STEP_TEST;
            end
            STEP_TEST: begin
               w.cond   = COND_C_OVER;
               w.jump_t = STEP_FAIL;
               w.jump_f = STEP_CHECK;
            end
            STEP_CHECK: begin
               w.cond   = COND_FITS;
               w.jump_t = STEP_PLACE;
               w.jump_f = STEP_INCC;
            end
            STEP_INCC: begin
               w.inc_c  = 1'b1;
               w.jump_t = STEP_TEST;
               w.jump_f = STEP_TEST;
            end
            STEP_PLACE: begin
               w.write_c = 1'b1;
               w.inc_v   = 1'b1;
               w.cond    = COND_V_LAST;
               w.jump_t  = STEP_EMITPREP;
               w.jump_f  = STEP_LOADC;
            end
            STEP_FAIL: begin
               w.clr_color_v = 1'b1;
               w.cond        = COND_V_ZERO;
               w.jump_t      = STEP_NEXTM;
               w.jump_f      = STEP_DEC;
            end
            STEP_DEC: begin
               w.dec_v  = 1'b1;
               w.jump_t = STEP_LOADC;
               w.jump_f = STEP_LOADC;
            end
            STEP_NEXTM: begin
               w.cond   = COND_M_FULL;
               w.jump_t = STEP_GIVEUP;
               w.jump_f = STEP_INCM;
            end
            STEP_INCM: begin
               w.inc_m  = 1'b1;
               w.jump_t = STEP_TRIAL;
               w.jump_f = STEP_TRIAL;
            end
            STEP_GIVEUP: begin
               w.clr_colors = 1'b1;
               w.jump_t     = STEP_EMITPREP;
               w.jump_f     = STEP_EMITPREP;
            end
            STEP_EMITPREP: begin
               w.clr_o  = 1'b1;
               w.jump_t = STEP_EMIT;
               w.jump_f = STEP_EMIT;
            end
            STEP_EMIT: begin
               w.emit   = 1'b1;
               w.cond   = COND_OUT_LAST;
               w.jump_t = STEP_IDLE;
               w.jump_f = STEP_EMIT;
            end
            default: begin
               w.jump_t = STEP_IDLE;
               w.jump_f = STEP_IDLE;
            end
         endcase
         return w;
      end
   endfunction

endpackage

FILE: sv/min_graph_coloring_search_unit.sv
// adjacency rows are taken one per cycle while the microprogram is idle;
// after the final row the microprogram runs the backtracking search, stepping
// through test, check and advance for each color tried at a vertex, so the search length depends on the graph
// results then stream one per cycle, one per vertex of the clamped count, under rsp_stall
// synchronous active-high reset: microprogram at idle, row count zero,
// vertex_count 16; the adjacency rows are not reset
module min_graph_coloring_search_unit
   import mgcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COLOR_W-1:0] csr_data
);

   step_type             upc_ff, upc_in;
   ctrl_word_type        ctrl;
   logic                 cond_hit;

   logic [ROW_W-1:0]     adj_ff [MAX_VERTICES];
   logic [COLOR_W-1:0]   colors_ff [MAX_VERTICES];
   logic [COLOR_W-1:0]   colors_in [MAX_VERTICES];
   logic [COLOR_W-1:0]   rows_ff, rows_in;
   logic [COLOR_W-1:0]   vcount_ff, vcount_in;
   logic [COLOR_W-1:0]   m_ff, m_in;
   logic [COLOR_W-1:0]   v_ff, v_in;
   logic [COLOR_W-1:0]   c_ff, c_in;
   logic [VIDX_W-1:0]    o_ff, o_in;

   logic [COLOR_W-1:0]   n_eff;
   logic                 req_acc;
   logic                 rsp_acc;
   logic                 row_write;
   logic [ROW_W-1:0]     cur_row;
   logic                 conflict;

   // control word for the current step
   always_comb begin
      ctrl = ucode(upc_ff);
   end

   assign req_stall = !ctrl.accept_req;
   assign rsp_valid = ctrl.emit;
   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign row_write = req_acc && (rows_ff < COLOR_W'(MAX_VERTICES));

   // vertex count clamped to 1..MAX_VERTICES
   always_comb begin
      if (vcount_ff == '0) begin
         n_eff = COLOR_W'(1);
      end else if (vcount_ff > COLOR_W'(MAX_VERTICES)) begin
         n_eff = COLOR_W'(MAX_VERTICES);
      end else begin
         n_eff = vcount_ff;
      end
   end

   // candidate color clashes with an earlier colored neighbor
   assign cur_row = adj_ff[v_ff[VIDX_W-1:0]];
   always_comb begin
      conflict = 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (cur_row[i] && (COLOR_W'(i) < v_ff) && (colors_ff[i] == c_ff)) begin
            conflict = 1'b1;
         end
      end
   end

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_START:    cond_hit = req_acc && req_data.last_row;
         COND_C_OVER:   cond_hit = c_ff > m_ff;
         COND_FITS:     cond_hit = !conflict;
         COND_V_LAST:   cond_hit = (v_ff + COLOR_W'(1)) >= n_eff;
         COND_V_ZERO:   cond_hit = v_ff == '0;
         COND_M_FULL:   cond_hit = m_ff == n_eff;
         COND_OUT_LAST: cond_hit = rsp_acc && ({1'b0, o_ff} == (n_eff - COLOR_W'(1)));
         default:       cond_hit = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      upc_in = cond_hit ? ctrl.jump_t : ctrl.jump_f;
   end

   // datapath next values
   always_comb begin
      vcount_in = vcount_ff;
      rows_in   = rows_ff;
      m_in      = m_ff;
      v_in      = v_ff;
      c_in      = c_ff;
      o_in      = o_ff;
      colors_in = colors_ff;

      if (csr_valid && csr_ready) begin
         vcount_in = csr_data;
      end
      if (row_write) begin
         rows_in = rows_ff + COLOR_W'(1);
      end
      if (req_acc && req_data.last_row) begin
         rows_in = '0;
      end
      if (ctrl.set_m1) begin
         m_in = COLOR_W'(1);
      end
      if (ctrl.inc_m) begin
         m_in = m_ff + COLOR_W'(1);
      end
      if (ctrl.clr_colors) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            colors_in[i] = '0;
         end
      end
      if (ctrl.clr_v) begin
         v_in = '0;
      end
      if (ctrl.inc_v) begin
         v_in = v_ff + COLOR_W'(1);
      end
      if (ctrl.dec_v) begin
         v_in = v_ff - COLOR_W'(1);
      end
      if (ctrl.load_c) begin
         c_in = colors_ff[v_ff[VIDX_W-1:0]] + COLOR_W'(1);
      end
      if (ctrl.inc_c) begin
         c_in = c_ff + COLOR_W'(1);
      end
      if (ctrl.write_c) begin
         colors_in[v_ff[VIDX_W-1:0]] = c_ff;
      end
      if (ctrl.clr_color_v) begin
         colors_in[v_ff[VIDX_W-1:0]] = '0;
      end
      if (ctrl.clr_o) begin
         o_in = '0;
      end
      if (ctrl.emit && rsp_acc) begin
         o_in = o_ff + VIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff    <= STEP_IDLE;
         rows_ff   <= '0;
         vcount_ff <= COLOR_W'(MAX_VERTICES);
         m_ff      <= COLOR_W'(1);
         v_ff      <= '0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            colors_ff[i] <= '0;
         end
      end else begin
         upc_ff    <= upc_in;
         rows_ff   <= rows_in;
         vcount_ff <= vcount_in;
         m_ff      <= m_in;
         v_ff      <= v_in;
         colors_ff <= colors_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      o_ff <= o_in;
      if (row_write) begin
         adj_ff[rows_ff[VIDX_W-1:0]] <= req_data.adjacency_row;
      end
   end

   always_comb begin
      rsp_data.vertex_index   = o_ff;
      rsp_data.assigned_color = colors_ff[o_ff];
      rsp_data.colors_used    = m_ff;
      rsp_data.last_vertex    = {1'b0, o_ff} == (n_eff - COLOR_W'(1));
   end

`ifndef SYNTHESIS
   a_color_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.assigned_color != '0) &&
                    (rsp_data.assigned_color <= rsp_data.colors_used))
      else $error("reported color outside 1..colors_used");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.colors_used <= n_eff) && ({1'b0, o_ff} < n_eff))
      else $error("color count or vertex index beyond vertex count");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_data.last_vertex) |=> (!rsp_valid && !req_stall))
      else $error("no return to loading after final result");
`endif

endmodule
